// ===== rtl/core/cfd_pkg.sv =====
// Shared constants, codes and item types of the checksummed frame deframer.
package cfd_pkg;

    localparam int FRAME_BYTES   = 44;
    localparam int IDX_W         = 6;
    localparam int PAYLOAD_FIRST = 3;
    localparam int PAYLOAD_COUNT = 40;
    localparam int PAYLOAD_BITS  = PAYLOAD_COUNT * 8;
    localparam int PADDR_W       = 3;

    localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX      = IDX_W'(PAYLOAD_FIRST);
    localparam logic [IDX_W-1:0] PAYLOAD_END    = IDX_W'(PAYLOAD_FIRST + PAYLOAD_COUNT);
    localparam logic [8:0]       CHECK_POS_MAX  = 9'(FRAME_BYTES - 1);
    localparam logic [8:0]       CHECK_OFFSET   = 9'(PAYLOAD_FIRST);

    localparam logic signed [31:0] REJECT_CODE = -32'sd1000;
    localparam logic [7:0]         SYNC_RESET  = 8'd7;
    localparam logic [7:0]         MIN_RESET   = 8'd5;

    typedef enum logic [0:0] {
        REG_SYNC_VALUE = 1'b0,
        REG_MIN_LENGTH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] min_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } byte_item_t;

    typedef struct packed {
        logic               frame_ok;
        logic signed [31:0] command;
        logic signed [31:0] int_arg;
        logic [63:0]        real_arg0;
        logic [63:0]        real_arg1;
        logic [63:0]        real_arg2;
        logic [63:0]        real_arg3;
    } result_item_t;

endpackage

// ===== rtl/core/checksummed_frame_deframer.sv =====
// Top level of the checksummed frame deframer: byte pipeline, checks and result register.
//
// The block receives a fixed receive buffer of 44 bytes, one byte item per
// accepted handshake on the byte channel (byte_valid, byte_stall, byte_item).
// A byte with frame_start set is always taken as byte 0 and abandons any
// partial buffer without a result; after reset and after the last byte of a
// buffer the next byte is byte 0 anyway. Byte 0 must match the sync value,
// byte 1 is a length that must reach the minimum length, and the 8-bit sum
// of that many bytes from offset 3 on must equal the byte right after them.
// After the last byte one result item leaves on the result channel
// (result_valid, result_stall, result_item): a good frame carries the
// command, the integer argument and four raw 64-bit words, all little endian;
// a bad frame carries command -1000 and the last good argument values.
// A byte is accepted every cycle unless byte_stall holds it; it lands in an
// input register, and the next cycle the per-byte compare, 8-bit add and
// payload shift run between that register and the frame state; a result item
// is then offered from the result register. While the result register holds an item that
// the receiver stalls, only a last byte waits in the input register; other
// bytes keep flowing. Reset clears the frame state (not the payload), the held arguments and
// both valid flags, and loads the register defaults (sync 7, minimum 5).
module checksummed_frame_deframer
    import cfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  byte_item_t         byte_item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_item_t       result_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t cfg;

    cfd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register stage.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    byte_item_t s1_item_reg;

    // Frame state.
    logic [IDX_W-1:0]        byte_index_reg;
    logic [IDX_W-1:0]        byte_index_next;
    logic [7:0]              length_reg;
    logic [7:0]              length_next;
    logic                    header_good_reg;
    logic                    header_good_next;
    logic [7:0]              sum_reg;
    logic [7:0]              sum_next;
    logic [7:0]              check_reg;
    logic [7:0]              check_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;
    logic signed [31:0]      held_int_reg;
    logic [63:0]             held_real_reg [4];

    // Result register.
    logic         result_valid_reg;
    logic         result_valid_next;
    result_item_t result_reg;
    result_item_t result_next;

    logic             accept;
    logic             s1_last;
    logic             s1_advance;
    logic [IDX_W-1:0] idx;
    logic [7:0]       b;
    logic [8:0]       check_pos;
    logic [8:0]       final_check_pos;
    logic             frame_ok;

    assign b   = s1_item_reg.data_byte;
    assign idx = s1_item_reg.frame_start ? '0 : byte_index_reg;

    assign s1_last    = (idx == LAST_IDX);
    // Only a last byte needs the result register; all others pass freely.
    assign s1_advance = s1_valid_reg && (!s1_last || !result_valid_reg || !result_stall);
    assign byte_stall = s1_valid_reg && !s1_advance;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Per-byte header, checksum and payload bookkeeping.
    assign check_pos = {1'b0, length_reg} + CHECK_OFFSET;

    always_comb
    begin
        length_next      = length_reg;
        header_good_next = header_good_reg;
        sum_next         = sum_reg;
        check_next       = check_reg;
        payload_next     = payload_reg;
        if (idx == '0)
        begin
            header_good_next = (b == cfg.sync_value);
            length_next      = 8'd0;
            sum_next         = 8'd0;
            check_next       = 8'd0;
        end
        else if (idx == IDX_W'(1))
        begin
            length_next = b;
            if (b < cfg.min_length)
            begin
                header_good_next = 1'b0;
            end
        end
        else if (idx >= FIRST_IDX)
        begin
            if ({3'd0, idx} < check_pos)
            begin
                sum_next = sum_reg + b;
            end
            else if ({3'd0, idx} == check_pos)
            begin
                check_next = b;
            end
            // Payload bytes enter at the top, so byte 3 ends up in the low byte.
            if (idx < PAYLOAD_END)
            begin
                payload_next = {b, payload_reg[PAYLOAD_BITS-1:8]};
            end
        end
    end

    assign byte_index_next = s1_last ? '0 : idx + IDX_W'(1);

    // The length byte is never the last one, so the stored length is final here.
    assign final_check_pos = {1'b0, length_next} + CHECK_OFFSET;
    assign frame_ok = header_good_next && (final_check_pos <= CHECK_POS_MAX)
                      && (sum_next == check_next);

    always_comb
    begin
        result_next.frame_ok = frame_ok;
        if (frame_ok)
        begin
            result_next.command   = $signed(payload_next[31:0]);
            result_next.int_arg   = $signed(payload_next[63:32]);
            result_next.real_arg0 = payload_next[127:64];
            result_next.real_arg1 = payload_next[191:128];
            result_next.real_arg2 = payload_next[255:192];
            result_next.real_arg3 = payload_next[319:256];
        end
        else
        begin
            result_next.command   = REJECT_CODE;
            result_next.int_arg   = held_int_reg;
            result_next.real_arg0 = held_real_reg[0];
            result_next.real_arg1 = held_real_reg[1];
            result_next.real_arg2 = held_real_reg[2];
            result_next.real_arg3 = held_real_reg[3];
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (s1_advance && s1_last)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            byte_index_reg   <= '0;
            length_reg       <= 8'd0;
            header_good_reg  <= 1'b0;
            sum_reg          <= 8'd0;
            check_reg        <= 8'd0;
            held_int_reg     <= '0;
            held_real_reg[0] <= '0;
            held_real_reg[1] <= '0;
            held_real_reg[2] <= '0;
            held_real_reg[3] <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (s1_advance)
            begin
                byte_index_reg  <= byte_index_next;
                length_reg      <= length_next;
                header_good_reg <= header_good_next;
                sum_reg         <= sum_next;
                check_reg       <= check_next;
                if (s1_last && frame_ok)
                begin
                    held_int_reg     <= result_next.int_arg;
                    held_real_reg[0] <= result_next.real_arg0;
                    held_real_reg[1] <= result_next.real_arg1;
                    held_real_reg[2] <= result_next.real_arg2;
                    held_real_reg[3] <= result_next.real_arg3;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= byte_item;
        end
        if (s1_advance)
        begin
            payload_reg <= payload_next;
        end
        if (s1_advance && s1_last)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

endmodule

// ===== rtl/core/cfd_apb_regs.sv =====
// APB configuration registers of the deframer: sync value and minimum length.
module cfd_apb_regs
    import cfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_reg_t reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_SYNC_VALUE: cfg_next.sync_value = pwdata[7:0];
                REG_MIN_LENGTH: cfg_next.min_length = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SYNC_VALUE: prdata = {24'd0, cfg_reg.sync_value};
            REG_MIN_LENGTH: prdata = {24'd0, cfg_reg.min_length};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value <= SYNC_RESET;
            cfg_reg.min_length <= MIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/cfd_checker.sv =====
// Port-level assertions for the deframer and the bind that attaches them.
module cfd_checker
    import cfd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         byte_stall,
    input logic         result_valid,
    input logic         result_stall,
    input result_item_t result_item
);

    logic signed [31:0] last_good_int_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_good_int_reg <= '0;
        end
        else if (result_valid && !result_stall && result_item.frame_ok)
        begin
            last_good_int_reg <= result_item.int_arg;
        end
    end

    // A rejected frame always carries the reject command.
    a_reject_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.frame_ok |-> result_item.command == REJECT_CODE)
        else $error("rejected frame without reject command");

    // A rejected frame repeats the integer argument of the last good frame.
    a_held_arg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.frame_ok |-> result_item.int_arg == last_good_int_reg)
        else $error("rejected frame did not hold last good argument");

    // The byte side only waits behind a result the receiver is stalling.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid && result_stall)
        else $error("byte channel stalled without a stalled result");

    // A stalled result stays offered and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("stalled result changed");

endmodule

bind checksummed_frame_deframer cfd_checker u_cfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);

// ===== verif/checksummed_frame_deframer_checker.sv =====
`timescale 1ns / 1ps
// Checker of the checksummed frame deframer: predicts every result item and compares it, and checks register reads.
module checksummed_frame_deframer_checker
    import cfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  logic               byte_stall,
    input  byte_item_t         byte_item,
    input  logic               result_valid,
    input  logic               result_stall,
    input  result_item_t       result_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 mismatch_count,
    output int                 results_pending
);

    localparam int REPORT_LIMIT = 10;

    // Register copies, written whenever a write completes on the configuration port.
    logic [7:0]       sync_value;
    logic [7:0]       min_length;

    // Frame state of the predictor.
    logic [IDX_W-1:0] next_index;
    logic [7:0]       length_seen;
    logic             header_good;
    logic [7:0]       running_sum;
    logic [7:0]       check_byte;
    logic [7:0]       payload [PAYLOAD_COUNT];
    logic [31:0]      held_int_arg;
    logic [63:0]      held_real [4];

    result_item_t     results_due [$];
    int               result_number;

    // Little-endian word of count payload bytes starting at payload offset first.
    function automatic logic [63:0] le_word(input int first, input int count);
        logic [63:0] word;
        word = '0;
        for (int k = count - 1; k >= 0; k--)
            word = {word[55:0], payload[first + k]};
        return word;
    endfunction

    // Advances the frame state by one accepted byte item and queues the result it causes.
    task automatic absorb_byte(input byte_item_t item);
        int           idx;
        int           check_pos;
        logic         good;
        result_item_t res;
        idx = item.frame_start ? 0 : int'(next_index);
        if (idx == 0) begin
            header_good = (item.data_byte == sync_value);
            length_seen = '0;
            running_sum = '0;
            check_byte  = '0;
        end else if (idx == 1) begin
            length_seen = item.data_byte;
            if (item.data_byte < min_length)
                header_good = 1'b0;
        end else if (idx >= PAYLOAD_FIRST) begin
            check_pos = int'(length_seen) + PAYLOAD_FIRST;
            if (idx < check_pos)
                running_sum += item.data_byte;
            else if (idx == check_pos)
                check_byte = item.data_byte;
            if (idx - PAYLOAD_FIRST < PAYLOAD_COUNT)
                payload[idx - PAYLOAD_FIRST] = item.data_byte;
        end

        if (idx + 1 < FRAME_BYTES) begin
            next_index = IDX_W'(idx + 1);
        end else begin
            next_index = '0;
            check_pos  = int'(length_seen) + PAYLOAD_FIRST;
            good = header_good && (check_pos <= FRAME_BYTES - 1) &&
                   (running_sum == check_byte);
            if (good) begin
                held_int_arg = 32'(le_word(4, 4));
                for (int k = 0; k < 4; k++)
                    held_real[k] = le_word(8 + 8 * k, 8);
            end
            res.frame_ok  = good;
            res.command   = good ? 32'(le_word(0, 4)) : REJECT_CODE;
            res.int_arg   = held_int_arg;
            res.real_arg0 = held_real[0];
            res.real_arg1 = held_real[1];
            res.real_arg2 = held_real[2];
            res.real_arg3 = held_real[3];
            results_due.push_back(res);
        end
    endtask

    task automatic note_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: item %0d, %s expected %h, got %h",
                         $time, result_number, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input result_item_t got);
        result_item_t want;
        if (results_due.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: item %0d arrived with no result expected, got %h",
                         $time, result_number, got);
            mismatch_count++;
        end else begin
            want = results_due.pop_front();
            note_field("frame_ok", want.frame_ok, got.frame_ok);
            note_field("command", want.command, got.command);
            note_field("int_arg", want.int_arg, got.int_arg);
            note_field("real_arg0", want.real_arg0, got.real_arg0);
            note_field("real_arg1", want.real_arg1, got.real_arg1);
            note_field("real_arg2", want.real_arg2, got.real_arg2);
            note_field("real_arg3", want.real_arg3, got.real_arg3);
        end
        result_number++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sync_value   = SYNC_RESET;
            min_length   = MIN_RESET;
            next_index   = '0;
            length_seen  = '0;
            header_good  = 1'b0;
            running_sum  = '0;
            check_byte   = '0;
            held_int_arg = '0;
            for (int k = 0; k < PAYLOAD_COUNT; k++)
                payload[k] = '0;
            for (int k = 0; k < 4; k++)
                held_real[k] = '0;
            results_due.delete();
            result_number   = 0;
            mismatch_count  = 0;
            results_pending = 0;
        end else begin
            if (result_valid && !result_stall)
                check_result(result_item);
            if (byte_valid && !byte_stall)
                absorb_byte(byte_item);
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (cfg_reg_t'(paddr[2]))
                        REG_SYNC_VALUE: sync_value = pwdata[7:0];
                        REG_MIN_LENGTH: min_length = pwdata[7:0];
                    endcase
                end else begin
                    note_field("prdata",
                               {56'h0, (cfg_reg_t'(paddr[2]) == REG_SYNC_VALUE) ?
                                       sync_value : min_length},
                               {32'h0, prdata});
                end
            end
            results_pending = results_due.size();
        end
    end

endmodule

// ===== verif/checksummed_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the checksummed frame deframer: clock, reset, stimulus, stalls and verdict.
module checksummed_frame_deframer_tb;
    import cfd_pkg::*;

    // Timing of the run. The watchdog limit sits well above the long receiver
    // hold so that only a real hang, or a result that never shows up, ends the run.
    localparam int RESET_CYCLES   = 7;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_BYTES    = 180;

    // How a frame is spoiled, if at all.
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SYNC,
        FRAME_SHORT_LEN,
        FRAME_BAD_SUM,
        FRAME_LONG_LEN
    } frame_kind_t;

    // Content of the bytes that the frame layout does not fix.
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    // Stall patterns of the result receiver.
    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               byte_valid   = 1'b0;
    logic               byte_stall;
    byte_item_t         byte_item    = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    result_item_t       result_item;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;

    int                 mismatch_count;
    int                 results_pending;

    // Sender bookkeeping: the buffer position it believes the block is at,
    // the current burst and whether gaps are allowed in this phase.
    logic [7:0]         frame_buf [FRAME_BYTES];
    logic [7:0]         cur_sync   = SYNC_RESET;
    logic [7:0]         cur_min    = MIN_RESET;
    int                 buf_pos    = 0;
    int                 burst_left = 0;
    int                 bytes_sent = 0;
    bit                 gaps_on    = 1'b1;

    // Receiver bookkeeping. The stimulus raises hold_request once; the receiver
    // turns it into a long hold that it counts down on its own.
    bit                 hold_request = 1'b0;
    bit                 hold_taken   = 1'b0;
    int                 hold_left    = 0;
    int                 mode_left    = 0;
    int                 stall_tick   = 0;
    stall_mode_t        stall_mode   = STALL_NONE;

    int                 idle_cycles  = 0;

    checksummed_frame_deframer u_dut (.*);

    checksummed_frame_deframer_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Receiver: switches between stall patterns after random stretches so that
    // stalls land on every position of a frame, with stall-free stretches too.
    always @(posedge clk)
    begin : receiver
        logic stall_now;
        if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
        end
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
        end
        else
        begin
            mode_left--;
        end
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  stall_now = 1'b0;
            STALL_HALF:  stall_now = 1'($urandom_range(0, 1));
            STALL_HEAVY: stall_now = ($urandom_range(0, 3) != 0);
            default:     stall_now = (stall_tick % 5 < 2);
        endcase
        if (hold_left > 0)
        begin
            stall_now = 1'b1;
            hold_left--;
        end
        result_stall <= stall_now;
    end

    // Watchdog: any cycle that moves an item, or completes a register access,
    // clears the count. A stuck block or a missing result runs it out.
    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
            (psel && penable && pready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one byte item and returns at the edge where it is accepted. When gaps
    // are on and a burst runs out, valid drops for a random gap before the next item.
    task automatic send_byte(input logic [7:0] data, input logic start);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 6);
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= '{data_byte: data, frame_start: start};
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        buf_pos = (start ? 0 : buf_pos) + 1;
        if (buf_pos == FRAME_BYTES)
            buf_pos = 0;
        bytes_sent++;
    endtask

    // Sends the first count bytes of frame_buf; only the first may carry frame_start.
    task automatic send_frame(input logic start_first, input int count);
        for (int i = 0; i < count; i++)
            send_byte(frame_buf[i], (i == 0) ? start_first : 1'b0);
    endtask

    // Lays out a frame of the given length under the current sync value. The
    // checksum lands right after the summed bytes whenever it fits in the buffer;
    // the kind then spoils the sync byte or the checksum as asked. A short or an
    // overlong length is simply the len that the caller passes.
    task automatic make_frame(input frame_kind_t kind, input int len, input fill_t fill);
        logic [7:0] sum;
        for (int i = 0; i < FRAME_BYTES; i++)
            case (fill)
                FILL_ZERO: frame_buf[i] = 8'h00;
                FILL_ONES: frame_buf[i] = 8'hFF;
                default:   frame_buf[i] = 8'($urandom_range(0, 255));
            endcase
        frame_buf[0] = cur_sync;
        frame_buf[1] = 8'(len);
        if (len <= PAYLOAD_COUNT)
        begin
            sum = 8'h00;
            for (int i = PAYLOAD_FIRST; i < PAYLOAD_FIRST + len; i++)
                sum += frame_buf[i];
            frame_buf[PAYLOAD_FIRST + len] = sum;
            if (kind == FRAME_BAD_SUM)
                frame_buf[PAYLOAD_FIRST + len] ^= 8'($urandom_range(1, 255));
        end
        if (kind == FRAME_BAD_SYNC)
            frame_buf[0] ^= 8'($urandom_range(1, 255));
    endtask

    // Length for a frame of the given kind under the current minimum. Good lengths
    // favor the minimum and the largest length whose checksum still fits.
    function automatic int pick_len(input frame_kind_t kind);
        if (kind == FRAME_LONG_LEN)
            return $urandom_range(PAYLOAD_COUNT + 1, 255);
        if (kind == FRAME_SHORT_LEN && cur_min != 0)
            return $urandom_range(0, int'(cur_min) - 1);
        if (cur_min > PAYLOAD_COUNT)
            return $urandom_range(0, 255);
        case ($urandom_range(0, 3))
            0:       return cur_min;
            1:       return PAYLOAD_COUNT;
            default: return $urandom_range(cur_min, PAYLOAD_COUNT);
        endcase
    endfunction

    // frame_start must be set when the block sits inside a buffer; at a buffer
    // boundary it is optional, since the block starts a new buffer either way.
    function automatic logic start_bit();
        if (buf_pos != 0)
            return 1'b1;
        return ($urandom_range(0, 3) != 0);
    endfunction

    // Waits until every expected result item has arrived, then the extra
    // cycles that the caller asks for, so that a byte still in the input register is absorbed.
    task automatic settle(input int extra);
        byte_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // One register access: a setup phase, an access phase held until pready,
    // then an idle phase before the next access may start.
    task automatic reg_access(input cfg_reg_t which, input logic write, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= PADDR_W'(int'(which) * 4);
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes both registers with the block idle and reads each back; the
    // checker compares the read data with its own copy.
    task automatic configure(input logic [7:0] sync, input logic [7:0] min_len);
        settle(SETTLE_CYCLES);
        reg_access(REG_SYNC_VALUE, 1'b1, sync);
        reg_access(REG_SYNC_VALUE, 1'b0, 8'h00);
        reg_access(REG_MIN_LENGTH, 1'b1, min_len);
        reg_access(REG_MIN_LENGTH, 1'b0, 8'h00);
        cur_sync = sync;
        cur_min  = min_len;
    endtask

    initial
    begin
        int          phase_end;
        int          pick;
        frame_kind_t kind;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset settings. The first buffer starts
        // without frame_start, as the block takes it as byte 0 after reset.
        make_frame(FRAME_GOOD, 5, FILL_RANDOM);
        send_frame(1'b0, FRAME_BYTES);
        // Largest length: the checksum is the very last byte of the buffer.
        make_frame(FRAME_GOOD, PAYLOAD_COUNT, FILL_ONES);
        send_frame(1'b1, FRAME_BYTES);
        // Rejected frames; each must keep the arguments of the last good one.
        make_frame(FRAME_SHORT_LEN, 4, FILL_RANDOM);
        send_frame(1'b0, FRAME_BYTES);
        make_frame(FRAME_LONG_LEN, PAYLOAD_COUNT + 1, FILL_RANDOM);
        send_frame(1'b1, FRAME_BYTES);
        make_frame(FRAME_LONG_LEN, 255, FILL_ZERO);
        send_frame(1'b0, FRAME_BYTES);
        make_frame(FRAME_BAD_SYNC, 20, FILL_RANDOM);
        send_frame(1'b1, FRAME_BYTES);
        make_frame(FRAME_BAD_SUM, 10, FILL_RANDOM);
        send_frame(1'b1, FRAME_BYTES);
        // A buffer abandoned halfway by a new frame_start gives no result.
        make_frame(FRAME_GOOD, 12, FILL_RANDOM);
        send_frame(1'b1, 20);
        make_frame(FRAME_GOOD, 33, FILL_ZERO);
        send_frame(1'b1, FRAME_BYTES);

        // Register extremes. With minimum zero an empty sum must match byte 3.
        configure(8'h00, 8'h00);
        make_frame(FRAME_GOOD, 0, FILL_RANDOM);
        send_frame(1'b1, FRAME_BYTES);
        make_frame(FRAME_GOOD, 0, FILL_ZERO);
        send_frame(1'b0, FRAME_BYTES);
        // A minimum of 255 leaves no length that passes.
        configure(8'hFF, 8'hFF);
        make_frame(FRAME_GOOD, PAYLOAD_COUNT, FILL_RANDOM);
        send_frame(1'b1, FRAME_BYTES);
        make_frame(FRAME_GOOD, 255, FILL_ONES);
        send_frame(1'b1, FRAME_BYTES);
        configure(8'hFF, 8'(PAYLOAD_COUNT));
        make_frame(FRAME_GOOD, PAYLOAD_COUNT, FILL_RANDOM);
        send_frame(1'b1, FRAME_BYTES);
        make_frame(FRAME_SHORT_LEN, PAYLOAD_COUNT - 1, FILL_RANDOM);
        send_frame(1'b0, FRAME_BYTES);

        // Random phases, each under fresh register values. Mostly whole frames,
        // good or spoiled in one way; the rest are abandoned buffers and noise.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            configure(8'($urandom_range(0, 255)),
                      ($urandom_range(0, 4) == 0) ? 8'($urandom_range(PAYLOAD_COUNT + 1, 255))
                                                  : 8'($urandom_range(0, PAYLOAD_COUNT)));
            gaps_on = (phase != 2);
            // One long hold while the sender keeps offering: the result
            // register fills, a last byte waits, and the byte channel stalls.
            if (phase == 1)
                hold_request = 1'b1;
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                begin
                    if (pick < 55)
                        kind = FRAME_GOOD;
                    else if (pick < 63)
                        kind = FRAME_BAD_SYNC;
                    else if (pick < 71)
                        kind = FRAME_SHORT_LEN;
                    else if (pick < 79)
                        kind = FRAME_BAD_SUM;
                    else
                        kind = FRAME_LONG_LEN;
                    make_frame(kind, pick_len(kind), FILL_RANDOM);
                    send_frame(start_bit(), FRAME_BYTES);
                end
                else if (pick < 93)
                begin
                    make_frame(FRAME_GOOD, pick_len(FRAME_GOOD), FILL_RANDOM);
                    send_frame(start_bit(), $urandom_range(1, FRAME_BYTES - 1));
                end
                else
                begin
                    repeat ($urandom_range(1, 60))
                        send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
                end
            end
            // Close the phase on a buffer boundary so the next write finds it idle.
            if (buf_pos != 0)
            begin
                make_frame(FRAME_GOOD, pick_len(FRAME_GOOD), FILL_RANDOM);
                send_frame(1'b1, FRAME_BYTES);
            end
        end

        settle(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
